@@ sv/ffha_pkg.sv @@
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int PAGE_BYTES_DEF   = 12288;
  localparam int OFFSET_BITS_DEF  = 24;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int LIMIT_BITS  = 24;
  localparam int STATUS_BITS = 3;

  localparam logic [LIMIT_BITS-1:0] HEAP_LIMIT_RST = 24'd16773120;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NULL     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;

  typedef logic [STATUS_BITS-1:0] status_t;

endpackage

@@ sv/first_fit_heap_allocator_core.sv @@
// the table walk reads one entry a cycle; an entry shift on insert or remove
// moves each entry through a read state (S_SHR or S_DR), then a write state
// (S_SHW or S_DW); a heap resize adds a page remainder via S_MUL, S_QP, S_MOD
// throughput: one transaction at a time; in_ready is high only while the sequencer idles
// reset: synchronous active-low rst_n; table holds only the sentinel, heap end is one
// page, heap limit returns to its default; no clearing pass
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int PAGE_BYTES   = ffha_pkg::PAGE_BYTES_DEF,
  parameter int OFFSET_BITS  = ffha_pkg::OFFSET_BITS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffha_pkg::LIMIT_BITS-1:0] cfg_heap_limit,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [OFFSET_BITS-1:0]          in_request_size,
  input  logic [OFFSET_BITS-1:0]          in_data_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ffha_pkg::status_t               out_status,
  output logic [OFFSET_BITS-1:0]          out_result_offset,
  output logic [OFFSET_BITS-1:0]          out_heap_end_now
);

  localparam int W   = OFFSET_BITS;
  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int PW  = $clog2(PAGE_BYTES) + 1;
  localparam int M1  = (W > PW) ? W : PW;
  localparam int M2  = (M1 > ffha_pkg::LIMIT_BITS) ? M1 : ffha_pkg::LIMIT_BITS;
  localparam int VW  = M2 + 2;
  localparam logic [VW-1:0] RECIP = VW'((64'(1) << VW) / 64'(PAGE_BYTES));

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_TAIL   = 4'd2;
  localparam logic [3:0] S_MOD    = 4'd3;
  localparam logic [3:0] S_GROW   = 4'd4;
  localparam logic [3:0] S_SHR    = 4'd5;
  localparam logic [3:0] S_SHW    = 4'd6;
  localparam logic [3:0] S_WR     = 4'd7;
  localparam logic [3:0] S_DR     = 4'd8;
  localparam logic [3:0] S_DW     = 4'd9;
  localparam logic [3:0] S_SHCHK  = 4'd10;
  localparam logic [3:0] S_SHRINK = 4'd11;
  localparam logic [3:0] S_RESP   = 4'd12;
  localparam logic [3:0] S_MUL    = 4'd13;
  localparam logic [3:0] S_QP     = 4'd14;

  logic [2*W-1:0] mem [MAX_BLOCKS];
  logic [2*W-1:0] rdata_r;
  logic           rsent_r;
  logic [AW-1:0]  mem_raddr;
  logic [AW-1:0]  mem_waddr;
  logic [2*W-1:0] mem_wdata;
  logic           mem_we;

  logic [3:0]                      state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [W-1:0]                    heap_end_r, heap_end_nxt;
  logic [ffha_pkg::LIMIT_BITS-1:0] limit_r;
  logic                            action_r, action_nxt;
  logic [W:0]                      total_r, total_nxt;
  logic [W-1:0]                    real_r, real_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   k_r, k_nxt;
  logic [CW-1:0]                   ins_pos_r, ins_pos_nxt;
  logic [W:0]                      prev_end_r, prev_end_nxt;
  logic [VW-1:0]                   mval_r, mval_nxt;
  logic [VW-1:0]                   mq_r, mq_nxt;
  logic [VW-1:0]                   mr_r, mr_nxt;
  logic [PW-1:0]                   mrem_r, mrem_nxt;
  ffha_pkg::status_t               st_r, st_nxt;
  logic [W-1:0]                    res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ffha_pkg::status_t               out_status_r, out_status_nxt;
  logic [W-1:0]                    out_res_r, out_res_nxt;
  logic [W-1:0]                    out_he_r, out_he_nxt;

  logic [W-1:0]    ent_start, ent_size;
  logic [W:0]      ent_start_x, ent_end;
  logic [W+1:0]    req_sum;
  logic            last_ent;
  logic [W:0]      he_x, remain;
  logic [2*VW-1:0] mprod;
  logic [VW-1:0]   newend, vmask;

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_offset = out_res_r;
  assign out_heap_end_now  = out_he_r;

  assign ent_start   = rsent_r ? '0 : rdata_r[2*W-1:W];
  assign ent_size    = rsent_r ? W'(HEADER_BYTES) : rdata_r[W-1:0];
  assign ent_start_x = {1'b0, ent_start};
  assign ent_end     = ent_start_x + {1'b0, ent_size};
  assign req_sum     = {2'b00, in_request_size} + (W+2)'(HEADER_BYTES + 7);
  assign last_ent    = (idx_r == count_r - CW'(1));
  assign he_x        = {1'b0, heap_end_r};
  assign remain      = (he_x > prev_end_r) ? (he_x - prev_end_r) : '0;
  assign mprod       = {{VW{1'b0}}, mval_r} * {{VW{1'b0}}, RECIP};
  assign vmask       = {{(VW-W){1'b0}}, {W{1'b1}}};
  assign newend      = VW'(heap_end_r) + (mval_r - VW'(mrem_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
    rsent_r <= (mem_raddr == '0);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    heap_end_nxt  = heap_end_r;
    action_nxt    = action_r;
    total_nxt     = total_r;
    real_nxt      = real_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    ins_pos_nxt   = ins_pos_r;
    prev_end_nxt  = prev_end_r;
    mval_nxt      = mval_r;
    mq_nxt        = mq_r;
    mr_nxt        = mr_r;
    mrem_nxt      = mrem_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    out_status_nxt = out_status_r;
    out_res_nxt   = out_res_r;
    out_he_nxt    = out_he_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_raddr     = AW'(1);
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt   = in_action;
          total_nxt    = {req_sum[W:3], 3'b000};
          idx_nxt      = CW'(1);
          prev_end_nxt = (W+1)'(HEADER_BYTES);
          real_nxt     = in_data_offset - W'(HEADER_BYTES);
          res_nxt      = '0;
          if (!in_action) begin
            if (in_request_size == '0) begin
              st_nxt    = ffha_pkg::ST_NULL;
              state_nxt = S_RESP;
            end else if (count_r == CW'(MAX_BLOCKS)) begin
              st_nxt    = ffha_pkg::ST_FULL;
              state_nxt = S_RESP;
            end else if (count_r == CW'(1)) begin
              state_nxt = S_TAIL;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (in_data_offset == '0) begin
              st_nxt    = ffha_pkg::ST_NULL;
              state_nxt = S_RESP;
            end else if (in_data_offset < W'(HEADER_BYTES) || count_r == CW'(1)) begin
              st_nxt    = ffha_pkg::ST_NOTFOUND;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        mem_raddr = idx_r[AW-1:0] + AW'(1);
        if (!action_r) begin
          if (ent_start_x >= prev_end_r && (ent_start_x - prev_end_r) >= total_r) begin
            ins_pos_nxt = idx_r;
            k_nxt       = count_r;
            state_nxt   = S_SHR;
          end else begin
            prev_end_nxt = ent_end;
            idx_nxt      = idx_r + CW'(1);
            if (last_ent) begin
              state_nxt = S_TAIL;
            end
          end
        end else begin
          if (ent_start == real_r) begin
            k_nxt = idx_r;
            if (last_ent) begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_SHCHK;
            end else begin
              state_nxt = S_DR;
            end
          end else if (last_ent) begin
            st_nxt    = ffha_pkg::ST_NOTFOUND;
            state_nxt = S_RESP;
          end else begin
            prev_end_nxt = ent_end;
            idx_nxt      = idx_r + CW'(1);
          end
        end
      end
      S_TAIL: begin
        if (remain >= total_r) begin
          ins_pos_nxt = count_r;
          state_nxt   = S_WR;
        end else begin
          mval_nxt  = VW'(total_r - remain) + VW'(PAGE_BYTES - 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mq_nxt    = mprod[2*VW-1:VW];
        state_nxt = S_QP;
      end
      S_QP: begin
        mr_nxt    = mval_r - mq_r * VW'(PAGE_BYTES);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (mr_r >= VW'(PAGE_BYTES)) begin
          mrem_nxt = PW'(mr_r - VW'(PAGE_BYTES));
        end else begin
          mrem_nxt = PW'(mr_r);
        end
        state_nxt = action_r ? S_SHRINK : S_GROW;
      end
      S_GROW: begin
        if (newend > VW'(limit_r) || newend > vmask) begin
          st_nxt    = ffha_pkg::ST_NOSPACE;
          state_nxt = S_RESP;
        end else begin
          heap_end_nxt = newend[W-1:0];
          ins_pos_nxt  = count_r;
          state_nxt    = S_WR;
        end
      end
      S_SHR: begin
        mem_raddr = AW'(k_r - CW'(1));
        state_nxt = S_SHW;
      end
      S_SHW: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = {ent_start, ent_size};
        k_nxt     = k_r - CW'(1);
        state_nxt = ((k_r - CW'(1)) == ins_pos_r) ? S_WR : S_SHR;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ins_pos_r[AW-1:0];
        mem_wdata = {prev_end_r[W-1:0], total_r[W-1:0]};
        count_nxt = count_r + CW'(1);
        st_nxt    = ffha_pkg::ST_OK;
        res_nxt   = prev_end_r[W-1:0] + W'(HEADER_BYTES);
        state_nxt = S_RESP;
      end
      S_DR: begin
        mem_raddr = AW'(k_r + CW'(1));
        state_nxt = S_DW;
      end
      S_DW: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = {ent_start, ent_size};
        k_nxt     = k_r + CW'(1);
        if ((k_r + CW'(2)) == count_r) begin
          count_nxt = count_r - CW'(1);
          st_nxt    = ffha_pkg::ST_OK;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_DR;
        end
      end
      S_SHCHK: begin
        if (he_x > prev_end_r &&
            VW'(he_x - prev_end_r) > VW'(2 * PAGE_BYTES)) begin
          mval_nxt  = VW'(he_x - prev_end_r);
          state_nxt = S_MUL;
        end else begin
          st_nxt    = ffha_pkg::ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_SHRINK: begin
        heap_end_nxt = prev_end_r[W-1:0] + W'(mrem_r);
        st_nxt       = ffha_pkg::ST_OK;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_res_nxt    = res_r;
          out_he_nxt     = heap_end_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      heap_end_r  <= W'(PAGE_BYTES);
      limit_r     <= ffha_pkg::HEAP_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      heap_end_r  <= heap_end_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_heap_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    total_r      <= total_nxt;
    real_r       <= real_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    ins_pos_r    <= ins_pos_nxt;
    prev_end_r   <= prev_end_nxt;
    mval_r       <= mval_nxt;
    mq_r         <= mq_nxt;
    mr_r         <= mr_nxt;
    mrem_r       <= mrem_nxt;
    st_r         <= st_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
    out_he_r     <= out_he_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(1) && count_r <= CW'(MAX_BLOCKS))
    else $error("block count out of range");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::ST_OK |-> out_result_offset == '0)
    else $error("failed transaction carries an offset");

  a_idle_heap_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(heap_end_r) && $stable(count_r))
    else $error("heap state changed while idle");

  a_mod_below_page: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOD |=> mrem_r < PW'(PAGE_BYTES))
    else $error("page remainder out of range");

endmodule
